### src/gjdc_pkg.sv
// ----------------------------------------------------------------------------
// Gregorian / Julian day converter package
// Shared types, calendar constants and reciprocal constants for the
// constant divisions of the converter pipeline.
// ----------------------------------------------------------------------------
package gjdc_pkg;

   typedef enum logic {
      CMD_TO_JDN  = 1'b0,
      CMD_TO_DATE = 1'b1
   } cmd_type;

   typedef logic [13:0] year_type;
   typedef logic [3:0]  month_type;
   typedef logic [4:0]  day_type;
   typedef logic [4:0]  hour_type;
   typedef logic [5:0]  minute_type;
   typedef logic [5:0]  second_type;
   typedef logic [22:0] jdn_type;
   typedef logic [16:0] sod_type;

   // Register stages from an accepted item to its result.
   localparam int unsigned PIPE_DEPTH = 8;

   localparam int unsigned DAYS_400Y     = 146097;
   localparam int unsigned DAYS_4Y       = 1461;
   localparam int unsigned MONTH_SPAN    = 153;
   localparam int unsigned CENTURY       = 100;
   localparam int unsigned JDN_BASE      = 1721119;
   localparam int unsigned SHIFT_DAYS    = 1753164;
   localparam int unsigned SHIFT_YEARS   = 4800;
   localparam int unsigned YEAR_BIAS     = 400;
   localparam int unsigned JDN_OFFSET    = JDN_BASE - DAYS_400Y;
   localparam int unsigned DAY_SHIFT     = SHIFT_DAYS - JDN_BASE;
   localparam int unsigned JDN_MIN       = 1721060;
   localparam int unsigned JDN_MAX       = 7705192;
   localparam int unsigned SECS_PER_DAY  = 86400;
   localparam int unsigned SECS_PER_HOUR = 3600;
   localparam int unsigned SECS_PER_MIN  = 60;
   localparam int unsigned MONTH_MARCH   = 3;
   localparam int unsigned MONTH_ROLL    = 10;
   localparam int unsigned DAYS_PER_5    = 5;

   // Each reciprocal is ceil(2^S / D) with S = N + ceil(log2 D), which makes
   // the truncated product the exact quotient for every N-bit dividend.
   localparam int unsigned CENT_SHIFT = 22;
   localparam logic [15:0] CENT_MAGIC = 16'(((64'd1 << CENT_SHIFT) + 64'(CENTURY)
                                             - 64'd1) / 64'(CENTURY));
   localparam int unsigned CY_SHIFT = 43;
   localparam logic [25:0] CY_MAGIC = 26'(((64'd1 << CY_SHIFT) + 64'(DAYS_400Y)
                                           - 64'd1) / 64'(DAYS_400Y));
   localparam int unsigned YY_SHIFT = 29;
   localparam logic [18:0] YY_MAGIC = 19'(((64'd1 << YY_SHIFT) + 64'(DAYS_4Y)
                                           - 64'd1) / 64'(DAYS_4Y));
   localparam int unsigned MM_SHIFT = 19;
   localparam logic [11:0] MM_MAGIC = 12'(((64'd1 << MM_SHIFT) + 64'(MONTH_SPAN)
                                           - 64'd1) / 64'(MONTH_SPAN));
   localparam int unsigned DAY_SHIFT5 = 11;
   localparam logic [8:0]  DAY_MAGIC = 9'(((64'd1 << DAY_SHIFT5) + 64'(DAYS_PER_5)
                                          - 64'd1) / 64'(DAYS_PER_5));
   localparam int unsigned HOUR_SHIFT = 29;
   localparam logic [17:0] HOUR_MAGIC = 18'(((64'd1 << HOUR_SHIFT)
                                            + 64'(SECS_PER_HOUR) - 64'd1)
                                           / 64'(SECS_PER_HOUR));
   localparam int unsigned MIN_SHIFT = 18;
   localparam logic [12:0] MIN_MAGIC = 13'(((64'd1 << MIN_SHIFT)
                                           + 64'(SECS_PER_MIN) - 64'd1)
                                          / 64'(SECS_PER_MIN));

   // Days from the start of the March-based year to the first of the month,
   // (153 * m + 2) / 5, indexed by the calendar month as given. Month 0 acts
   // as December of the year before, months above 12 run on past February.
   function automatic logic [8:0] month_days(input month_type mo);
      logic [8:0] days;
      case (mo)
         4'd0:    days = 9'd275;
         4'd1:    days = 9'd306;
         4'd2:    days = 9'd337;
         4'd3:    days = 9'd0;
         4'd4:    days = 9'd31;
         4'd5:    days = 9'd61;
         4'd6:    days = 9'd92;
         4'd7:    days = 9'd122;
         4'd8:    days = 9'd153;
         4'd9:    days = 9'd184;
         4'd10:   days = 9'd214;
         4'd11:   days = 9'd245;
         4'd12:   days = 9'd275;
         4'd13:   days = 9'd306;
         4'd14:   days = 9'd337;
         default: days = 9'd367;
      endcase
      return days;
   endfunction

endpackage

### src/gjdc_req_if.sv
// ----------------------------------------------------------------------------
// Converter request channel
// Valid/ready channel carrying one conversion request item.
// ----------------------------------------------------------------------------
interface gjdc_req_if import gjdc_pkg::*; ();
   logic       valid;
   logic       ready;
   cmd_type    cmd;
   year_type   year;
   month_type  month;
   day_type    day;
   hour_type   hour;
   minute_type minute;
   second_type second;
   jdn_type    day_number;
   sod_type    seconds_in;

   modport source (
      output valid, cmd, year, month, day, hour, minute, second, day_number,
             seconds_in,
      input  ready
   );

   modport sink (
      input  valid, cmd, year, month, day, hour, minute, second, day_number,
             seconds_in,
      output ready
   );
endinterface

### src/gjdc_rsp_if.sv
// ----------------------------------------------------------------------------
// Converter response channel
// Valid/ready channel carrying one conversion result item.
// ----------------------------------------------------------------------------
interface gjdc_rsp_if import gjdc_pkg::*; ();
   logic       valid;
   logic       ready;
   jdn_type    jdn_out;
   sod_type    seconds_out;
   year_type   year_out;
   month_type  month_out;
   day_type    day_out;
   hour_type   hour_out;
   minute_type minute_out;
   second_type second_out;

   modport source (
      output valid, jdn_out, seconds_out, year_out, month_out, day_out,
             hour_out, minute_out, second_out,
      input  ready
   );

   modport sink (
      input  valid, jdn_out, seconds_out, year_out, month_out, day_out,
             hour_out, minute_out, second_out,
      output ready
   );
endinterface

### src/gjdc_to_jdn.sv
// ----------------------------------------------------------------------------
// Date to day number datapath
// Four working stages turn a Gregorian date and time of day into the civil
// day number and seconds of the day, then a delay line evens the latency.
// ----------------------------------------------------------------------------
module gjdc_to_jdn import gjdc_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  year_type   year,
   input  month_type  month,
   input  day_type    day,
   input  hour_type   hour,
   input  minute_type minute,
   input  second_type second,
   output jdn_type    jdn,
   output sod_type    seconds
);

   localparam int unsigned JDN_PAD = PIPE_DEPTH - 4;

   typedef struct packed {
      logic [14:0] year;
      logic [8:0]  mterm;
      day_type     day;
      sod_type     sod;
   } s1_type;

   typedef struct packed {
      logic [7:0]  cent;
      logic [14:0] year;
      logic [8:0]  mterm;
      day_type     day;
      sod_type     sod;
   } s2_type;

   typedef struct packed {
      jdn_type     cterm;
      logic [6:0]  yr;
      logic [8:0]  mterm;
      day_type     day;
      sod_type     sod;
   } s3_type;

   typedef struct packed {
      jdn_type jdn;
      sod_type sod;
   } res_type;

   s1_type  s1_in, s1_ff;
   s2_type  s2_in, s2_ff;
   s3_type  s3_in, s3_ff;
   res_type s4_in, s4_ff;
   res_type pad_in [JDN_PAD];
   res_type pad_ff [JDN_PAD];

   logic [30:0] cent_prod;
   logic [24:0] cterm_prod;
   logic [17:0] yterm_prod;

   // January and February count as months 11 and 12 of the year before; the
   // bias keeps the year positive through the century split.
   always_comb begin
      s1_in.year  = 15'(year) + 15'(YEAR_BIAS)
                    - ((month >= 4'(MONTH_MARCH)) ? 15'd0 : 15'd1);
      s1_in.mterm = month_days(month);
      s1_in.day   = day;
      s1_in.sod   = 17'(hour) * 17'(SECS_PER_HOUR) + 17'(minute) * 17'(SECS_PER_MIN)
                    + 17'(second);
   end

   assign cent_prod = 31'(s1_ff.year) * 31'(CENT_MAGIC);

   always_comb begin
      s2_in.cent  = cent_prod[CENT_SHIFT +: 8];
      s2_in.year  = s1_ff.year;
      s2_in.mterm = s1_ff.mterm;
      s2_in.day   = s1_ff.day;
      s2_in.sod   = s1_ff.sod;
   end

   assign cterm_prod = 25'(s2_ff.cent) * 25'(DAYS_400Y);

   always_comb begin
      s3_in.cterm = cterm_prod[24:2];
      s3_in.yr    = 7'(s2_ff.year - 15'(s2_ff.cent) * 15'(CENTURY));
      s3_in.mterm = s2_ff.mterm;
      s3_in.day   = s2_ff.day;
      s3_in.sod   = s2_ff.sod;
   end

   assign yterm_prod = 18'(s3_ff.yr) * 18'(DAYS_4Y);

   always_comb begin
      s4_in.jdn = 23'(s3_ff.day) + s3_ff.cterm + 23'(yterm_prod[17:2])
                  + 23'(s3_ff.mterm) + 23'(JDN_OFFSET);
      s4_in.sod = s3_ff.sod;
   end

   always_comb begin
      pad_in[0] = s4_ff;
      for (int i = 1; i < JDN_PAD; i++) begin
         pad_in[i] = pad_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         pad_ff <= pad_in;
      end
   end

   assign jdn     = pad_ff[JDN_PAD - 1].jdn;
   assign seconds = pad_ff[JDN_PAD - 1].sod;

endmodule

### src/gjdc_to_date.sv
// ----------------------------------------------------------------------------
// Day number to date datapath
// Eight stages split a civil day number into year, month and day through
// three chained constant divisions, each a reciprocal multiply followed by
// a remainder stage, and a final reciprocal divide by five for the day.
// ----------------------------------------------------------------------------
module gjdc_to_date import gjdc_pkg::*; (
   input  logic      clock,
   input  logic      en,
   input  jdn_type   day_number,
   output year_type  year,
   output month_type month,
   output day_type   day
);

   typedef struct packed {
      logic [7:0]  cy;
      logic [24:0] t;
   } s2_type;

   typedef struct packed {
      logic [7:0]  cy;
      logic [17:0] u;
   } s3_type;

   typedef struct packed {
      logic [7:0]  cy;
      logic [6:0]  yy;
      logic [17:0] u;
   } s4_type;

   typedef struct packed {
      logic [14:0] ysum;
      logic [10:0] v;
   } s5_type;

   typedef struct packed {
      logic [14:0] ysum;
      logic [3:0]  mm;
      logic [10:0] v;
   } s6_type;

   typedef struct packed {
      logic [14:0] ysum;
      logic [3:0]  mm;
      logic [7:0]  dd;
   } s7_type;

   typedef struct packed {
      year_type  year;
      month_type month;
      day_type   day;
   } s8_type;

   jdn_type     jd_clamp;
   logic [24:0] s1_in, s1_ff;
   s2_type      s2_in, s2_ff;
   s3_type      s3_in, s3_ff;
   s4_type      s4_in, s4_ff;
   s5_type      s5_in, s5_ff;
   s6_type      s6_in, s6_ff;
   s7_type      s7_in, s7_ff;
   s8_type      s8_in, s8_ff;

   logic [50:0] cy_prod;
   logic [24:0] r1;
   logic [36:0] yy_prod;
   logic [10:0] r2;
   logic [8:0]  d3;
   logic [22:0] mm_prod;
   logic [7:0]  r3;
   logic [16:0] day_prod;

   // Out-of-range day numbers are pinned to 0000-01-01 .. 16383-12-31 so the
   // year always fits.
   always_comb begin
      if (day_number < 23'(JDN_MIN)) begin
         jd_clamp = 23'(JDN_MIN);
      end else if (day_number > 23'(JDN_MAX)) begin
         jd_clamp = 23'(JDN_MAX);
      end else begin
         jd_clamp = day_number;
      end
      s1_in = ((25'(jd_clamp) + 25'(DAY_SHIFT)) << 2) - 25'd1;
   end

   assign cy_prod = 51'(s1_ff) * 51'(CY_MAGIC);

   always_comb begin
      s2_in.cy = cy_prod[CY_SHIFT +: 8];
      s2_in.t  = s1_ff;
   end

   // Rounding the remainder down to a multiple of four and adding three is
   // the same as forcing its two low bits high.
   assign r1 = s2_ff.t - 25'(s2_ff.cy) * 25'(DAYS_400Y);

   always_comb begin
      s3_in.cy = s2_ff.cy;
      s3_in.u  = {r1[17:2], 2'b11};
   end

   assign yy_prod = 37'(s3_ff.u) * 37'(YY_MAGIC);

   always_comb begin
      s4_in.cy = s3_ff.cy;
      s4_in.yy = yy_prod[YY_SHIFT +: 7];
      s4_in.u  = s3_ff.u;
   end

   always_comb begin
      r2         = 11'(s4_ff.u - 18'(s4_ff.yy) * 18'(DAYS_4Y));
      d3         = 9'((12'(r2) + 12'd4) >> 2);
      s5_in.v    = 11'(d3) * 11'(DAYS_PER_5) - 11'd3;
      s5_in.ysum = 15'(s4_ff.cy) * 15'(CENTURY) + 15'(s4_ff.yy);
   end

   assign mm_prod = 23'(s5_ff.v) * 23'(MM_MAGIC);

   always_comb begin
      s6_in.ysum = s5_ff.ysum;
      s6_in.mm   = mm_prod[MM_SHIFT +: 4];
      s6_in.v    = s5_ff.v;
   end

   always_comb begin
      r3         = 8'(s6_ff.v - 11'(s6_ff.mm) * 11'(MONTH_SPAN));
      s7_in.ysum = s6_ff.ysum;
      s7_in.mm   = s6_ff.mm;
      s7_in.dd   = r3 + 8'd5;
   end

   assign day_prod = 17'(s7_ff.dd) * 17'(DAY_MAGIC);

   // The March-based year rolls over to the calendar year in January.
   always_comb begin
      s8_in.day = day_prod[DAY_SHIFT5 +: 5];
      if (s7_ff.mm < 4'(MONTH_ROLL)) begin
         s8_in.month = s7_ff.mm + 4'd3;
         s8_in.year  = 14'(s7_ff.ysum - 15'(SHIFT_YEARS));
      end else begin
         s8_in.month = s7_ff.mm - 4'd9;
         s8_in.year  = 14'(s7_ff.ysum + 15'd1 - 15'(SHIFT_YEARS));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
         s5_ff <= s5_in;
         s6_ff <= s6_in;
         s7_ff <= s7_in;
         s8_ff <= s8_in;
      end
   end

   assign year  = s8_ff.year;
   assign month = s8_ff.month;
   assign day   = s8_ff.day;

endmodule

### src/gjdc_tod.sv
// ----------------------------------------------------------------------------
// Time of day splitter
// Reduces seconds since midnight into one day and splits them into hour,
// minute and second, then a delay line evens the latency.
// ----------------------------------------------------------------------------
module gjdc_tod import gjdc_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  sod_type    seconds_in,
   output hour_type   hour,
   output minute_type minute,
   output second_type second
);

   localparam int unsigned TOD_PAD = PIPE_DEPTH - 5;

   typedef struct packed {
      hour_type hour;
      sod_type  sod;
   } s2_type;

   typedef struct packed {
      hour_type    hour;
      logic [11:0] rem;
   } s3_type;

   typedef struct packed {
      hour_type    hour;
      minute_type  minute;
      logic [11:0] rem;
   } s4_type;

   typedef struct packed {
      hour_type   hour;
      minute_type minute;
      second_type second;
   } res_type;

   sod_type     s1_in, s1_ff;
   s2_type      s2_in, s2_ff;
   s3_type      s3_in, s3_ff;
   s4_type      s4_in, s4_ff;
   res_type     s5_in, s5_ff;
   res_type     pad_in [TOD_PAD];
   res_type     pad_ff [TOD_PAD];

   logic [34:0] hour_prod;
   logic [24:0] min_prod;

   // The field can exceed one day by less than a day, so one subtract wraps
   // it; no day is carried.
   assign s1_in = (seconds_in >= 17'(SECS_PER_DAY)) ? seconds_in - 17'(SECS_PER_DAY)
                                                    : seconds_in;

   assign hour_prod = 35'(s1_ff) * 35'(HOUR_MAGIC);

   always_comb begin
      s2_in.hour = hour_prod[HOUR_SHIFT +: 5];
      s2_in.sod  = s1_ff;
   end

   always_comb begin
      s3_in.hour = s2_ff.hour;
      s3_in.rem  = 12'(s2_ff.sod - 17'(s2_ff.hour) * 17'(SECS_PER_HOUR));
   end

   assign min_prod = 25'(s3_ff.rem) * 25'(MIN_MAGIC);

   always_comb begin
      s4_in.hour   = s3_ff.hour;
      s4_in.minute = min_prod[MIN_SHIFT +: 6];
      s4_in.rem    = s3_ff.rem;
   end

   always_comb begin
      s5_in.hour   = s4_ff.hour;
      s5_in.minute = s4_ff.minute;
      s5_in.second = 6'(s4_ff.rem - 12'(s4_ff.minute) * 12'(SECS_PER_MIN));
   end

   always_comb begin
      pad_in[0] = s5_ff;
      for (int i = 1; i < TOD_PAD; i++) begin
         pad_in[i] = pad_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         pad_ff <= pad_in;
      end
   end

   assign hour   = pad_ff[TOD_PAD - 1].hour;
   assign minute = pad_ff[TOD_PAD - 1].minute;
   assign second = pad_ff[TOD_PAD - 1].second;

endmodule

### src/gregorian_julian_day_converter_core.sv
// ----------------------------------------------------------------------------
// Gregorian / Julian day converter core
// Converts a Gregorian date and time to the civil day number and seconds of
// the day, or a day number and seconds back to a date and time.
// ----------------------------------------------------------------------------
// The core accepts one item per clock and returns its results in order; the
// pipeline depth is set by the day-number-to-date path, whose three chained
// constant divisions each take a reciprocal-multiply stage and a remainder
// stage, ahead of a final divide by five. When the response side stalls, the
// whole pipeline holds and the request side sees ready low for as long as the
// stall lasts. Fields that the chosen operation does not produce read as zero.
module gregorian_julian_day_converter_core import gjdc_pkg::*; (
   input  logic clock,
   input  logic reset,
   gjdc_req_if.sink   req_ch,
   gjdc_rsp_if.source rsp_ch
);

   logic                  advance;
   logic [PIPE_DEPTH-1:0] vld_in, vld_ff;
   logic [PIPE_DEPTH-1:0] cmd_in, cmd_ff;
   logic                  is_date;

   jdn_type    jdn;
   sod_type    sod;
   year_type   year;
   month_type  month;
   day_type    day;
   hour_type   hour;
   minute_type minute;
   second_type second;

   // The pipeline moves as one; it holds only while a finished item waits.
   assign advance      = !vld_ff[PIPE_DEPTH-1] || rsp_ch.ready;
   assign req_ch.ready = advance;

   assign vld_in = {vld_ff[PIPE_DEPTH-2:0], req_ch.valid};
   assign cmd_in = {cmd_ff[PIPE_DEPTH-2:0], req_ch.cmd};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cmd_ff <= cmd_in;
      end
   end

   gjdc_to_jdn u_to_jdn (
      .clock   (clock),
      .en      (advance),
      .year    (req_ch.year),
      .month   (req_ch.month),
      .day     (req_ch.day),
      .hour    (req_ch.hour),
      .minute  (req_ch.minute),
      .second  (req_ch.second),
      .jdn     (jdn),
      .seconds (sod)
   );

   gjdc_to_date u_to_date (
      .clock      (clock),
      .en         (advance),
      .day_number (req_ch.day_number),
      .year       (year),
      .month      (month),
      .day        (day)
   );

   gjdc_tod u_tod (
      .clock      (clock),
      .en         (advance),
      .seconds_in (req_ch.seconds_in),
      .hour       (hour),
      .minute     (minute),
      .second     (second)
   );

   assign is_date = (cmd_type'(cmd_ff[PIPE_DEPTH-1]) == CMD_TO_DATE);

   assign rsp_ch.valid       = vld_ff[PIPE_DEPTH-1];
   assign rsp_ch.jdn_out     = is_date ? '0 : jdn;
   assign rsp_ch.seconds_out = is_date ? '0 : sod;
   assign rsp_ch.year_out    = is_date ? year : '0;
   assign rsp_ch.month_out   = is_date ? month : '0;
   assign rsp_ch.day_out     = is_date ? day : '0;
   assign rsp_ch.hour_out    = is_date ? hour : '0;
   assign rsp_ch.minute_out  = is_date ? minute : '0;
   assign rsp_ch.second_out  = is_date ? second : '0;

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid straight after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |=> $stable(vld_ff) && $stable(cmd_ff))
      else $error("pipeline moved while the output item was stalled");

   a_date_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && is_date |->
         rsp_ch.month_out >= 4'd1 && rsp_ch.month_out <= 4'd12 &&
         rsp_ch.day_out >= 5'd1 && rsp_ch.day_out <= 5'd31 &&
         rsp_ch.hour_out <= 5'd23 && rsp_ch.minute_out <= 6'd59 &&
         rsp_ch.second_out <= 6'd59)
      else $error("date result field out of calendar range");
`endif

endmodule

### test/gregorian_julian_day_converter_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian / Julian day converter result checker
// Watches the request and response channels. Every accepted request item is
// converted by an independent calendar calculation, and every accepted
// response item is compared with the oldest conversion still waiting.
// ----------------------------------------------------------------------------
module gregorian_julian_day_converter_core_checker import gjdc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   gjdc_req_if         req_mon,
   gjdc_rsp_if         rsp_mon,
   output int unsigned failures,
   output int unsigned outstanding,
   output int unsigned date_items,
   output int unsigned day_items
);

   localparam int unsigned REPORT_LIMIT = 10;

   localparam longint QUAD_CENTURY_DAYS = 146097;
   localparam longint QUAD_YEAR_DAYS    = 1461;
   localparam longint MARCH_BASE_JDN    = 1721119;
   localparam longint EPOCH_SHIFT_DAYS  = 1753164;
   localparam longint EPOCH_SHIFT_YEARS = 4800;
   localparam longint DAY_SECONDS       = 86400;

   typedef struct packed {
      cmd_type    cmd;
      year_type   year;
      month_type  month;
      day_type    day;
      hour_type   hour;
      minute_type minute;
      second_type second;
      jdn_type    day_number;
      sod_type    seconds_in;
   } conv_request_type;

   typedef struct packed {
      jdn_type    jdn;
      sod_type    sod;
      year_type   year;
      month_type  month;
      day_type    day;
      hour_type   hour;
      minute_type minute;
      second_type second;
   } conv_result_type;

   conv_result_type awaited_results[$];

   // Day number of a proleptic Gregorian date. The year is counted from
   // March, and a bias of four centuries keeps every quotient non-negative.
   function automatic longint civil_day_number(longint y, longint mo, longint d);
      longint m, yr, c;
      yr = y;
      if (mo > 2) begin
         m = mo - 3;
      end else begin
         m = mo + 9;
         yr = yr - 1;
      end
      yr = yr + 400;
      c = yr / 100;
      yr = yr - 100 * c;
      return d + (c * QUAD_CENTURY_DAYS) / 4 + (yr * QUAD_YEAR_DAYS) / 4
             + (m * 153 + 2) / 5 + MARCH_BASE_JDN - QUAD_CENTURY_DAYS;
   endfunction

   function automatic conv_result_type convert_request(conv_request_type rq);
      conv_result_type r;
      longint jd, j, cy, dd, yy, mm, yr, secs, lo, hi;
      r = '0;
      if (rq.cmd == CMD_TO_JDN) begin
         jd = civil_day_number(longint'(rq.year), longint'(rq.month), longint'(rq.day));
         secs = longint'(rq.second) + 60 * (longint'(rq.minute) + 60 * longint'(rq.hour));
         r.jdn = jdn_type'(jd);
         r.sod = sod_type'(secs);
      end else begin
         // The day number is pinned to the span that a 14-bit year can show.
         lo = civil_day_number(0, 1, 1);
         hi = civil_day_number(16383, 12, 31);
         jd = longint'(rq.day_number);
         if (jd < lo) jd = lo;
         if (jd > hi) jd = hi;
         secs = longint'(rq.seconds_in) % DAY_SECONDS;
         j = jd - MARCH_BASE_JDN + EPOCH_SHIFT_DAYS;
         cy = (4 * j - 1) / QUAD_CENTURY_DAYS;
         j = 4 * j - 1 - QUAD_CENTURY_DAYS * cy;
         dd = j / 4;
         yy = (4 * dd + 3) / QUAD_YEAR_DAYS;
         dd = 4 * dd + 3 - QUAD_YEAR_DAYS * yy;
         dd = (dd + 4) / 4;
         mm = (5 * dd - 3) / 153;
         dd = 5 * dd - 3 - 153 * mm;
         dd = (dd + 5) / 5;
         yr = 100 * cy + yy - EPOCH_SHIFT_YEARS;
         if (mm < 10) begin
            mm = mm + 3;
         end else begin
            mm = mm - 9;
            yr = yr + 1;
         end
         r.year   = year_type'(yr);
         r.month  = month_type'(mm);
         r.day    = day_type'(dd);
         r.hour   = hour_type'(secs / 3600);
         r.minute = minute_type'((secs / 60) % 60);
         r.second = second_type'(secs % 60);
      end
      return r;
   endfunction

   always @(posedge clock) begin : watch
      conv_request_type rq;
      conv_result_type  got;
      conv_result_type  want;
      if (reset) begin
         awaited_results.delete();
         outstanding <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.jdn    = rsp_mon.jdn_out;
            got.sod    = rsp_mon.seconds_out;
            got.year   = rsp_mon.year_out;
            got.month  = rsp_mon.month_out;
            got.day    = rsp_mon.day_out;
            got.hour   = rsp_mon.hour_out;
            got.minute = rsp_mon.minute_out;
            got.second = rsp_mon.second_out;
            if (awaited_results.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("%0t: result item with no request waiting: jdn=%0d sod=%0d",
                           $realtime, got.jdn, got.sod);
               failures = failures + 1;
            end else begin
               want = awaited_results.pop_front();
               if (got !== want) begin
                  if (failures < REPORT_LIMIT) begin
                     $display("%0t: expected jdn=%0d sod=%0d date=%0d-%0d-%0d %0d:%0d:%0d",
                              $realtime, want.jdn, want.sod, want.year, want.month,
                              want.day, want.hour, want.minute, want.second);
                     $display("%0t: actual   jdn=%0d sod=%0d date=%0d-%0d-%0d %0d:%0d:%0d",
                              $realtime, got.jdn, got.sod, got.year, got.month,
                              got.day, got.hour, got.minute, got.second);
                  end
                  failures = failures + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rq.cmd        = req_mon.cmd;
            rq.year       = req_mon.year;
            rq.month      = req_mon.month;
            rq.day        = req_mon.day;
            rq.hour       = req_mon.hour;
            rq.minute     = req_mon.minute;
            rq.second     = req_mon.second;
            rq.day_number = req_mon.day_number;
            rq.seconds_in = req_mon.seconds_in;
            awaited_results.push_back(convert_request(rq));
            if (rq.cmd == CMD_TO_JDN)
               date_items = date_items + 1;
            else
               day_items = day_items + 1;
         end
         outstanding <= awaited_results.size();
      end
   end

endmodule

### test/gregorian_julian_day_converter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gregorian / Julian day converter testbench
// Drives directed calendar corner cases and then a random mix of valid and
// malformed conversion requests, with random idle gaps on the request side
// and random stalls on the response side; the checker does the comparison.
// ----------------------------------------------------------------------------
module gregorian_julian_day_converter_core_tb;
   import gjdc_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1850;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = PIPE_DEPTH + 8;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        calm = 1'b0;
   logic        result_ready = 1'b0;
   int unsigned stall_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count;
   int unsigned in_flight;
   int unsigned date_items;
   int unsigned day_items;

   gjdc_req_if req_if ();
   gjdc_rsp_if rsp_if ();

   assign rsp_if.ready = result_ready;

   gregorian_julian_day_converter_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   gregorian_julian_day_converter_core_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .failures    (mismatch_count),
      .outstanding (in_flight),
      .date_items  (date_items),
      .day_items   (day_items)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mostly short pauses, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin : drain_control
      int unsigned n;
      if (reset) begin
         result_ready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         result_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         n = calm ? 0 : pick_gap();
         if (n == 0) begin
            result_ready <= 1'b1;
         end else begin
            result_ready <= 1'b0;
            stall_left <= n - 1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("run stopped after %0d cycles with %0d results outstanding",
                  cycle_count, in_flight);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Presents one item and returns at the edge where it is accepted.
   task automatic offer_request(cmd_type c, year_type y, month_type mo, day_type d,
                                hour_type h, minute_type mi, second_type s,
                                jdn_type jn, sod_type secs);
      req_if.valid      <= 1'b1;
      req_if.cmd        <= c;
      req_if.year       <= y;
      req_if.month      <= mo;
      req_if.day        <= d;
      req_if.hour       <= h;
      req_if.minute     <= mi;
      req_if.second     <= s;
      req_if.day_number <= jn;
      req_if.seconds_in <= secs;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // The fields that the other operation uses carry junk, which must be ignored.
   task automatic offer_date(year_type y, month_type mo, day_type d,
                             hour_type h, minute_type mi, second_type s);
      offer_request(CMD_TO_JDN, y, mo, d, h, mi, s,
                    jdn_type'($urandom), sod_type'($urandom));
   endtask

   task automatic offer_day(jdn_type jn, sod_type secs);
      offer_request(CMD_TO_DATE, year_type'($urandom), month_type'($urandom),
                    day_type'($urandom), hour_type'($urandom), minute_type'($urandom),
                    second_type'($urandom), jn, secs);
   endtask

   task automatic idle_gap();
      int unsigned n;
      n = calm ? 0 : pick_gap();
      if (n != 0) begin
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int unsigned r;
      int unsigned y;
      int unsigned mo;
      int unsigned last_day;
      req_if.valid      = 1'b0;
      req_if.cmd        = CMD_TO_JDN;
      req_if.year       = '0;
      req_if.month      = '0;
      req_if.day        = '0;
      req_if.hour       = '0;
      req_if.minute     = '0;
      req_if.second     = '0;
      req_if.day_number = '0;
      req_if.seconds_in = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Calendar limits, leap days, year zero and the Gregorian changeover.
      offer_date(1, 1, 1, 0, 0, 0);              idle_gap();
      offer_date(9999, 12, 31, 23, 59, 60);      idle_gap();
      offer_date(0, 1, 1, 0, 0, 0);              idle_gap();
      offer_date(0, 2, 29, 12, 0, 0);            idle_gap();
      offer_date(0, 3, 1, 0, 0, 1);              idle_gap();
      offer_date(2000, 2, 29, 6, 30, 0);         idle_gap();
      offer_date(1900, 3, 1, 0, 0, 0);           idle_gap();
      offer_date(1582, 10, 15, 0, 0, 0);         idle_gap();
      // Out-of-range date and time fields go through the formula unchanged.
      offer_date(2024, 0, 15, 1, 2, 3);          idle_gap();
      offer_date(2023, 13, 1, 0, 0, 0);          idle_gap();
      offer_date(16383, 15, 31, 31, 63, 63);     idle_gap();
      offer_date(1999, 6, 0, 0, 0, 0);           idle_gap();
      offer_date(0, 0, 0, 0, 0, 0);              idle_gap();
      // Day numbers inside, at and beyond the saturation limits.
      offer_day(0, 0);                           idle_gap();
      offer_day(23'h7FFFFF, 17'h1FFFF);          idle_gap();
      offer_day(1721060, 1);                     idle_gap();
      offer_day(7705192, 86399);                 idle_gap();
      offer_day(1721426, 0);                     idle_gap();
      offer_day(5373484, 86399);                 idle_gap();
      offer_day(2451545, 43200);                 idle_gap();
      // Seconds of the day at and above one full day wrap round.
      offer_day(2299161, 86400);                 idle_gap();
      offer_day(2460000, 131071);                idle_gap();

      for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
         calm <= ((i / 150) % 4) == 2;
         r = $urandom_range(0, 99);
         if (r < 42) begin
            y = $urandom_range(1, 9999);
            mo = $urandom_range(1, 12);
            case (mo)
               2:          last_day = ((y % 4 == 0) && (y % 100 != 0 || y % 400 == 0)) ? 29 : 28;
               4, 6, 9, 11: last_day = 30;
               default:    last_day = 31;
            endcase
            offer_date(year_type'(y), month_type'(mo), day_type'($urandom_range(1, last_day)),
                       hour_type'($urandom_range(0, 23)), minute_type'($urandom_range(0, 59)),
                       second_type'($urandom_range(0, 60)));
         end else if (r < 52) begin
            offer_date(year_type'($urandom), month_type'($urandom), day_type'($urandom),
                       hour_type'($urandom), minute_type'($urandom), second_type'($urandom));
         end else if (r < 90) begin
            offer_day(jdn_type'($urandom_range(1721426, 5373484)),
                      sod_type'($urandom_range(0, 86399)));
         end else begin
            offer_day(jdn_type'($urandom), sod_type'($urandom));
         end
         idle_gap();
      end
      req_if.valid <= 1'b0;

      @(posedge clock);
      while (in_flight != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d date-to-day-number and %0d day-number-to-date items converted",
               date_items, day_items);
      $display("%0d results failed comparison in %0d cycles", mismatch_count, cycle_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
